// ===== hdl/cr3_pkg.sv =====
// Shared types and widths for the 3x3 Cramer's-rule solver.
// No dependencies; used by cr3_det, cr3_div and linear_system_solver_3x3_unit.
package cr3_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int DW  = DATA_WIDTH;
  localparam int PW  = 2 * DW;      // product of two operands
  localparam int MW  = 2 * DW + 1;  // 2x2 minor
  localparam int DTW = 3 * DW + 1;  // full determinant, signed
  localparam int DMW = 3 * DW;      // determinant magnitude
  localparam int SH  = DW - FRAC_BITS;

  // column sets of the four determinants: system, then column i replaced by rhs
  localparam logic [1:0] COLS [4][3] = '{
    '{2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd1, 2'd2},
    '{2'd0, 2'd3, 2'd2},
    '{2'd0, 2'd1, 2'd3}
  };

  typedef struct packed {
    logic signed [DW-1:0] coef_r0_c0;
    logic signed [DW-1:0] coef_r0_c1;
    logic signed [DW-1:0] coef_r0_c2;
    logic signed [DW-1:0] rhs_r0;
    logic signed [DW-1:0] coef_r1_c0;
    logic signed [DW-1:0] coef_r1_c1;
    logic signed [DW-1:0] coef_r1_c2;
    logic signed [DW-1:0] rhs_r1;
    logic signed [DW-1:0] coef_r2_c0;
    logic signed [DW-1:0] coef_r2_c1;
    logic signed [DW-1:0] coef_r2_c2;
    logic signed [DW-1:0] rhs_r2;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] unknown_0;
    logic signed [DW-1:0] unknown_1;
    logic signed [DW-1:0] unknown_2;
    logic                 singular;
    logic                 overflow;
  } out_t;

  typedef logic [3:0][DTW-1:0] dets_t;

  typedef struct packed {
    logic [DMW-1:0] rem;
    logic [DMW-1:0] den;
    logic [DW-1:0]  nlo;
    logic [DW-1:0]  q;
    logic           neg;
    logic           ovf;
    logic           zero;
  } div_st_t;

endpackage

// ===== hdl/linear_system_solver_3x3_unit.sv =====
// Top level of the 3x3 Cramer's-rule solver.
// Depends on cr3_pkg, cr3_det and cr3_div.
//
// Solves one 3x3 system in signed Q16.16 per transaction and accepts a new
// transaction on every clock cycle: busy never rises. Each transaction gives
// one result on out_item, marked by a single-cycle out_valid pulse, after
// exact determinant arithmetic and then three parallel pipelined dividers
// that retire one quotient bit per stage.
// The result cannot be held off, so the receiver must take it in
// that cycle. A zero system determinant gives singular with zero unknowns;
// an unknown outside the Q16.16 range saturates and raises overflow.
module linear_system_solver_3x3_unit import cr3_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  // Fully pipelined; nothing ever holds off a transaction.
  assign busy = 1'b0;

  logic  det_valid;
  dets_t dets;

  cr3_det u_det (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (start && !busy),
    .item     (in_item),
    .valid_out(det_valid),
    .dets     (dets)
  );

  logic          dv   [3];
  logic [DW-1:0] quo  [3];
  logic          ovf  [3];
  logic          zero [3];

  // Divide each column-replaced determinant by the system determinant.
  for (genvar i = 0; i < 3; i++) begin : g_div
    cr3_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .valid_in (det_valid),
      .num      ($signed(dets[i+1])),
      .den      ($signed(dets[0])),
      .valid_out(dv[i]),
      .quo      (quo[i]),
      .ovf      (ovf[i]),
      .zero     (zero[i])
    );
  end

  assign out_valid          = dv[0];
  assign out_item.unknown_0 = quo[0];
  assign out_item.unknown_1 = quo[1];
  assign out_item.unknown_2 = quo[2];
  assign out_item.singular  = zero[0];
  assign out_item.overflow  = ovf[0] | ovf[1] | ovf[2];

  // Check that a singular system reports no overflow.
  a_sing_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.singular && out_item.overflow))
    else $error("singular result with overflow");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.singular) |->
      (out_item.unknown_0 == '0 && out_item.unknown_1 == '0 &&
       out_item.unknown_2 == '0))
    else $error("singular result with nonzero unknowns");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (dv[0] == dv[1]) && (dv[1] == dv[2]))
    else $error("divider lanes out of step");

endmodule

// ===== hdl/cr3_det.sv =====
// Five-stage determinant pipeline: pair products, minors, partial products,
// terms, sums. Depends on cr3_pkg.
module cr3_det import cr3_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  valid_in,
  input  in_t   item,
  output logic  valid_out,
  output dets_t dets
);

  logic signed [DW-1:0] r0 [4];
  logic signed [DW-1:0] r1 [4];
  logic signed [DW-1:0] r2 [4];

  assign r0 = '{item.coef_r0_c0, item.coef_r0_c1, item.coef_r0_c2, item.rhs_r0};
  assign r1 = '{item.coef_r1_c0, item.coef_r1_c1, item.coef_r1_c2, item.rhs_r1};
  assign r2 = '{item.coef_r2_c0, item.coef_r2_c1, item.coef_r2_c2, item.rhs_r2};

  logic [4:0] vld_r;
  logic signed [DW-1:0]  r0_s1_r [4];
  logic signed [DW-1:0]  r0_s2_r [4];
  logic signed [PW-1:0]  p_r  [4][4];
  logic signed [MW-1:0]  m_r  [4][4];
  logic signed [MW-1:0]  hi_r [4][3];
  logic signed [MW-1:0]  lo_r [4][3];
  logic signed [DTW-1:0] t_r  [4][3];
  logic signed [DTW-1:0] d_r  [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    r0_s1_r <= r0;
    r0_s2_r <= r0_s1_r;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p_r[i][j] <= PW'(r1[i]) * PW'(r2[j]);
        m_r[i][j] <= MW'(p_r[i][j]) - MW'(p_r[j][i]);
      end
    end
    for (int k = 0; k < 4; k++) begin
      for (int t = 0; t < 3; t++) begin
        // row-0 operand times the minor of the two remaining columns
        hi_r[k][t] <= MW'(r0_s2_r[COLS[k][t]]) * MW'($signed(
          m_r[COLS[k][(t == 0) ? 1 : 0]][COLS[k][(t == 2) ? 1 : 2]][MW-1:DW]));
        lo_r[k][t] <= MW'(r0_s2_r[COLS[k][t]]) * $signed({{(MW-DW){1'b0}},
          m_r[COLS[k][(t == 0) ? 1 : 0]][COLS[k][(t == 2) ? 1 : 2]][DW-1:0]});
        t_r[k][t] <= (DTW'(hi_r[k][t]) <<< DW) + DTW'(lo_r[k][t]);
      end
      d_r[k] <= t_r[k][0] - t_r[k][1] + t_r[k][2];
    end
  end

  assign valid_out = vld_r[4];
  always_comb begin
    for (int k = 0; k < 4; k++) dets[k] = d_r[k];
  end

endmodule

// ===== hdl/cr3_div.sv =====
// Pipelined restoring divider: (num * 2^FRAC_BITS) / den, truncated and
// saturated, one quotient bit per stage. Depends on cr3_pkg.
module cr3_div import cr3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_in,
  input  logic signed [DTW-1:0] num,
  input  logic signed [DTW-1:0] den,
  output logic                  valid_out,
  output logic [DW-1:0]         quo,
  output logic                  ovf,
  output logic                  zero
);

  logic           va_r, vb_r;
  logic [DMW-1:0] nm_r, dm_r;
  logic           neg_r, zero_r;
  logic [DTW-1:0] nabs, dabs;

  assign nabs = num[DTW-1] ? DTW'(-num) : DTW'(num);
  assign dabs = den[DTW-1] ? DTW'(-den) : DTW'(den);

  // take magnitudes
  always_ff @(posedge clk) begin
    nm_r   <= nabs[DMW-1:0];
    dm_r   <= dabs[DMW-1:0];
    neg_r  <= num[DTW-1] ^ den[DTW-1];
    zero_r <= (den == '0);
  end

  div_st_t st_r [DW+1];
  logic    sv_r [DW+1];

  // a quotient of 2^DW or more is flagged to saturate; the remainder is seeded as well
  always_ff @(posedge clk) begin
    st_r[0].rem  <= DMW'(nm_r >> SH);
    st_r[0].nlo  <= {nm_r[SH-1:0], {FRAC_BITS{1'b0}}};
    st_r[0].den  <= dm_r;
    st_r[0].q    <= '0;
    st_r[0].neg  <= neg_r;
    st_r[0].zero <= zero_r;
    st_r[0].ovf  <= ({{SH{1'b0}}, nm_r} >= ({{SH{1'b0}}, dm_r} << SH));
  end

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [DMW:0] trial;
    div_st_t      st_nxt;
    assign trial = {st_r[k].rem, st_r[k].nlo[DW-1]} - {1'b0, st_r[k].den};
    always_comb begin
      st_nxt     = st_r[k];
      st_nxt.nlo = {st_r[k].nlo[DW-2:0], 1'b0};
      if (!trial[DMW]) begin
        st_nxt.rem = trial[DMW-1:0];
        st_nxt.q   = {st_r[k].q[DW-2:0], 1'b1};
      end else begin
        st_nxt.rem = {st_r[k].rem[DMW-2:0], st_r[k].nlo[DW-1]};
        st_nxt.q   = {st_r[k].q[DW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      st_r[k+1] <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      for (int k = 0; k <= DW; k++) sv_r[k] <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      va_r  <= valid_in;
      sv_r[0] <= va_r;
      for (int k = 0; k < DW; k++) sv_r[k+1] <= sv_r[k];
      vb_r <= sv_r[DW];
      valid_out <= vb_r;
    end
  end

  // saturate and restore sign
  div_st_t fin_r;
  logic [DW-1:0] lim, qs;
  logic          ov;
  always_ff @(posedge clk) fin_r <= st_r[DW];

  always_comb begin
    lim = fin_r.neg ? (DW'(1) << (DW-1)) : ((DW'(1) << (DW-1)) - DW'(1));
    ov  = fin_r.ovf || (fin_r.q > lim);
    qs  = ov ? lim : fin_r.q;
  end

  always_ff @(posedge clk) begin
    zero <= fin_r.zero;
    if (fin_r.zero) begin
      quo <= '0;
      ovf <= 1'b0;
    end else begin
      quo <= fin_r.neg ? DW'(-qs) : qs;
      ovf <= ov;
    end
  end

endmodule
